[src/espa_pkg.sv]
`default_nettype none

package espa_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int AGE_W      = 18;
	localparam int DT_W       = 13;
	localparam int SCALE_W    = 10;
	localparam int POS_W      = 32;
	localparam int SEED_W     = 32;
	localparam int DROP_W     = 32;
	localparam int SPAWN_W    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [15:0]        MAX_TICK  = 16'd4369;
	localparam logic [AGE_W-1:0]   MIN_LIFE  = 18'd66;
	localparam logic [SCALE_W-1:0] SCALE_MIN = 10'd154;
	localparam logic [SCALE_W-1:0] SCALE_MAX = 10'd640;
	localparam logic [AGE_W-1:0]   AGE_MAX   = {AGE_W{1'b1}};
	localparam logic [SPAWN_W-1:0] SPAWN_CAP = 4'd8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPAWN_LIM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIFETIME   = 3'd3;

	typedef enum logic [1:0] {
		MODE_FRAME = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_SPAWN = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		OUT_NONE     = 3'd0,
		OUT_GRANTED  = 3'd1,
		OUT_RATE_LIM = 3'd2,
		OUT_FULL     = 3'd3,
		OUT_DISABLED = 3'd4
	} outcome_t;

	// timing entry of one slot, read and written back by the sweep
	typedef struct packed {
		logic [AGE_W-1:0] age;
		logic [AGE_W-1:0] life;
	} timing_entry_t;

	// geometry entry of one slot, written on a grant
	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic [SEED_W-1:0]  seed;
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic [POS_W-1:0]   pos_z;
	} payload_entry_t;

endpackage

`default_nettype wire

[src/expiring_slot_pool_allocator.sv]
`default_nettype none

// A tick or an enabled spawn sweeps the timing memory once per slot, then passes a
// drain state and a decision state that loads the result word once the output register
// is free; a frame start, a disabled spawn or an unused mode goes straight to decision.
// A new item is taken only in the idle state, so the block is through with one item
// before it takes the next; the sweep is paced by the single read port of the timing memory.
// Reset: clears configuration to defaults, valid bits, counters and control; memories
// are not cleared and no clearing pass runs.
module expiring_slot_pool_allocator
	import espa_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,

	input  wire logic                    cfg_write,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,

	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [1:0]              mode,
	input  wire logic [15:0]             delta_time,
	input  wire logic signed [POS_W-1:0] pos_x,
	input  wire logic signed [POS_W-1:0] pos_y,
	input  wire logic signed [POS_W-1:0] pos_z,
	input  wire logic [SCALE_W-1:0]      size_scale,

	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [2:0]                   outcome,
	output logic [IDX_W-1:0]             slot_index,
	output logic [SEED_W-1:0]            effect_seed,
	output logic [CNT_W-1:0]             active_count,
	output logic [DROP_W-1:0]            dropped_total,
	output logic [SPAWN_W-1:0]           spawned_in_frame
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SWEEP  = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;

	// configuration
	logic                  enable_q;
	logic [6:0]            slot_limit_q;
	logic [SPAWN_W-1:0]    spawn_limit_q;
	logic [AGE_W-1:0]      lifetime_q;

	// item held while it is worked on
	logic [1:0]            mode_q;
	logic [DT_W-1:0]       dt_q;
	logic [SCALE_W-1:0]    scale_q;
	logic [POS_W-1:0]      pos_x_q;
	logic [POS_W-1:0]      pos_y_q;
	logic [POS_W-1:0]      pos_z_q;

	// slot state outside the memories
	logic [SLOT_COUNT-1:0] slot_active_q;
	logic [CNT_W-1:0]      active_cnt_q;
	logic [SPAWN_W-1:0]    frame_spawns_q;
	logic [DROP_W-1:0]     drop_q;
	logic [SEED_W-1:0]     seed_q;

	// sweep control
	logic [IDX_W-1:0]      sweep_idx_q;
	logic                  valid_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  found_v_q;
	logic [IDX_W-1:0]      found_q;

	// memories
	timing_entry_t         timing_mem [SLOT_COUNT];
	payload_entry_t        payload_mem [SLOT_COUNT];
	timing_entry_t         rd_s1;

	// output word register
	logic                  out_valid_q;
	logic [2:0]            outcome_q;
	logic [IDX_W-1:0]      slot_index_q;
	logic [SEED_W-1:0]     effect_seed_q;
	logic [CNT_W-1:0]      active_count_q;
	logic [DROP_W-1:0]     dropped_total_q;
	logic [SPAWN_W-1:0]    spawned_q;

	// effective limits
	logic [CNT_W-1:0]      lim;
	logic [SPAWN_W-1:0]    cap;
	logic [AGE_W-1:0]      life_eff;
	logic [SCALE_W-1:0]    scale_clamped;
	logic [15:0]           dt_clamped;

	always_comb begin
		if (slot_limit_q == 7'd0) begin
			lim = CNT_W'(1);
		end else if (slot_limit_q > 7'(SLOT_COUNT)) begin
			lim = CNT_W'(SLOT_COUNT);
		end else begin
			lim = slot_limit_q[CNT_W-1:0];
		end
		cap      = (spawn_limit_q > SPAWN_CAP) ? SPAWN_CAP : spawn_limit_q;
		life_eff = (lifetime_q < MIN_LIFE) ? MIN_LIFE : lifetime_q;
		if (size_scale < SCALE_MIN) begin
			scale_clamped = SCALE_MIN;
		end else if (size_scale > SCALE_MAX) begin
			scale_clamped = SCALE_MAX;
		end else begin
			scale_clamped = size_scale;
		end
		dt_clamped = (delta_time > MAX_TICK) ? MAX_TICK : delta_time;
	end

	// Stage s1: the timing entry of idx_s1 has arrived from the memory. Active slots at or
	// above the limit are evicted; active slots below it age on a tick, and the slots below
	// it are searched for the first free one on a spawn.
	logic                  act_s1;
	logic                  in_range_s1;
	logic                  evict_s1;
	logic                  ageing_s1;
	logic [AGE_W:0]        age_sum_s1;
	logic [AGE_W-1:0]      age_new_s1;
	logic                  expire_s1;
	logic                  clear_s1;
	logic                  free_hit_s1;

	always_comb begin
		act_s1      = slot_active_q[idx_s1];
		in_range_s1 = {1'b0, idx_s1} < lim;
		evict_s1    = valid_s1 && act_s1 && !in_range_s1;
		ageing_s1   = valid_s1 && act_s1 && in_range_s1 && (mode_q == MODE_TICK);
		age_sum_s1  = {1'b0, rd_s1.age} + (AGE_W+1)'(dt_q);
		age_new_s1  = age_sum_s1[AGE_W] ? AGE_MAX : age_sum_s1[AGE_W-1:0];
		expire_s1   = ageing_s1 && (age_new_s1 >= rd_s1.life);
		clear_s1    = evict_s1 || expire_s1;
		free_hit_s1 = valid_s1 && (mode_q == MODE_SPAWN) && in_range_s1 && !act_s1
			&& !found_v_q;
	end

	// Decision: load the output word once the register is free.
	logic                  out_free;
	logic                  fin;
	logic                  grant;
	logic                  refuse;
	outcome_t              outcome_n;

	assign out_free = !out_valid_q || out_ready;
	assign fin      = (state_q == ST_FINISH) && out_free;

	always_comb begin
		grant     = 1'b0;
		refuse    = 1'b0;
		outcome_n = OUT_NONE;
		case (mode_q)
			MODE_SPAWN: begin
				if (!enable_q) begin
					outcome_n = OUT_DISABLED;
				end else if (frame_spawns_q >= cap) begin
					outcome_n = OUT_RATE_LIM;
					refuse    = 1'b1;
				end else if (!found_v_q) begin
					outcome_n = OUT_FULL;
					refuse    = 1'b1;
				end else begin
					outcome_n = OUT_GRANTED;
					grant     = 1'b1;
				end
			end
			default: outcome_n = OUT_NONE;
		endcase
	end

	logic                  drop_inc;
	logic [DROP_W-1:0]     drop_n;
	logic [CNT_W-1:0]      active_cnt_n;
	logic [SPAWN_W-1:0]    frame_spawns_n;

	always_comb begin
		drop_inc = evict_s1 || (fin && refuse);
		drop_n   = (drop_inc && drop_q != {DROP_W{1'b1}}) ? drop_q + DROP_W'(1) : drop_q;
		if (clear_s1) begin
			active_cnt_n = active_cnt_q - CNT_W'(1);
		end else if (fin && grant) begin
			active_cnt_n = active_cnt_q + CNT_W'(1);
		end else begin
			active_cnt_n = active_cnt_q;
		end
		if (fin && mode_q == MODE_FRAME) begin
			frame_spawns_n = '0;
		end else if (fin && grant) begin
			frame_spawns_n = frame_spawns_q + SPAWN_W'(1);
		end else begin
			frame_spawns_n = frame_spawns_q;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b1;
			slot_limit_q  <= 7'd16;
			spawn_limit_q <= 4'd4;
			lifetime_q    <= 18'd32768;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ENABLE:     enable_q      <= cfg_data[0];
				REG_SLOT_LIMIT: slot_limit_q  <= cfg_data[6:0];
				REG_SPAWN_LIM:  spawn_limit_q <= cfg_data[SPAWN_W-1:0];
				REG_LIFETIME:   lifetime_q    <= cfg_data[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sweep_idx_q <= '0;
			valid_s1    <= 1'b0;
			found_v_q   <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SWEEP);
			if (free_hit_s1) begin
				found_v_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sweep_idx_q <= '0;
						found_v_q   <= 1'b0;
						if (mode == MODE_TICK || (mode == MODE_SPAWN && enable_q)) begin
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SWEEP: begin
					sweep_idx_q <= sweep_idx_q + IDX_W'(1);
					if (sweep_idx_q == IDX_W'(SLOT_COUNT - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the item; clamp delta and scale on the way in
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q  <= mode;
			dt_q    <= dt_clamped[DT_W-1:0];
			scale_q <= scale_clamped;
			pos_x_q <= pos_x;
			pos_y_q <= pos_y;
			pos_z_q <= pos_z;
		end
		idx_s1 <= sweep_idx_q;
		if (free_hit_s1) begin
			found_q <= idx_s1;
		end
	end

	// slot valid bits and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_active_q  <= '0;
			active_cnt_q   <= '0;
			frame_spawns_q <= '0;
			drop_q         <= '0;
			seed_q         <= '0;
		end else begin
			if (clear_s1) begin
				slot_active_q[idx_s1] <= 1'b0;
			end
			if (fin && grant) begin
				slot_active_q[found_q] <= 1'b1;
				seed_q                 <= seed_q + SEED_W'(1);
			end
			active_cnt_q   <= active_cnt_n;
			frame_spawns_q <= frame_spawns_n;
			drop_q         <= drop_n;
		end
	end

	// Timing memory: one read and one write a cycle. The sweep reads slot i+1
	// while it writes back slot i, and a grant writes only after the sweep has
	// drained, so no access to one entry ever overlaps.
	always_ff @(posedge clk) begin
		rd_s1 <= timing_mem[sweep_idx_q];
		if (ageing_s1) begin
			timing_mem[idx_s1] <= '{age: age_new_s1, life: rd_s1.life};
		end else if (fin && grant) begin
			timing_mem[found_q] <= '{age: '0, life: life_eff};
		end
	end

	// geometry memory: written on a grant
	always_ff @(posedge clk) begin
		if (fin && grant) begin
			payload_mem[found_q] <= '{scale: scale_q, seed: seed_q, pos_x: pos_x_q,
				pos_y: pos_y_q, pos_z: pos_z_q};
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			outcome_q       <= outcome_n;
			slot_index_q    <= grant ? found_q : '0;
			effect_seed_q   <= grant ? seed_q : '0;
			active_count_q  <= active_cnt_n;
			dropped_total_q <= drop_n;
			spawned_q       <= frame_spawns_n;
		end
	end

	assign out_valid        = out_valid_q;
	assign outcome          = outcome_q;
	assign slot_index       = slot_index_q;
	assign effect_seed      = effect_seed_q;
	assign active_count     = active_count_q;
	assign dropped_total    = dropped_total_q;
	assign spawned_in_frame = spawned_q;

`ifndef NO_ASSERTIONS
	// the running count tracks the valid bits
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		active_cnt_q == CNT_W'($countones(slot_active_q)))
		else $error("active count out of step with valid bits");

	// the sweep stage never runs while the block is idle
	a_s1_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
		else $error("sweep stage active outside a sweep");

	// the drop counter never goes back
	a_drop_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q >= $past(drop_q))
		else $error("drop counter decreased");

	// a granted slot is free when taken
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && grant) |-> !slot_active_q[found_q])
		else $error("grant of an active slot");
`endif

endmodule

`default_nettype wire
